// ----- sv/lsh_pkg.sv -----
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants of the 3x3 Laplacian sharpening filter.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [11:0] WIDTH_RESET    = 12'd640;
    localparam logic [15:0] HEIGHT_RESET   = 16'd480;
    localparam logic [2:0]  CHANNELS_RESET = 3'd1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic emit;
        logic border;
        logic last_row;
        logic frame_end;
    } lsh_ctrl_t;

endpackage

// ----- sv/lsh_line_store.sv -----
// ----------------------------------------------------------------------------
// lsh_line_store
// Two line memories: row one above (two read ports) and row two above.
// ----------------------------------------------------------------------------
module lsh_line_store
    import lsh_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] rd_addr_right,
    input  logic          one_wr_en,
    input  pix_t          one_wr_data,
    input  logic          two_wr_en,
    input  logic [AW-1:0] two_wr_addr,
    input  pix_t          two_wr_data,
    output pix_t          centre,
    output pix_t          up,
    output pix_t          right
);

    pix_t one_mem [DEPTH];
    pix_t two_mem [DEPTH];

    pix_t centre_reg;
    pix_t up_reg;
    pix_t right_reg;

    // read-before-write on the shared address
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            centre_reg <= one_mem[rd_addr];
            right_reg  <= one_mem[rd_addr_right];
        end
        if (one_wr_en) begin
            one_mem[rd_addr] <= one_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            up_reg <= two_mem[rd_addr];
        end
        if (two_wr_en) begin
            two_mem[two_wr_addr] <= two_wr_data;
        end
    end

    assign centre = centre_reg;
    assign up     = up_reg;
    assign right  = right_reg;

endmodule

// ----- sv/lsh_kernel.sv -----
// ----------------------------------------------------------------------------
// lsh_kernel
// Read stage, stencil arithmetic with clamp, left-neighbor history and
// output register that emits zero, one or two words per input word.
// ----------------------------------------------------------------------------
module lsh_kernel
    import lsh_pkg::*;
#(
    parameter int MAX_CHANNELS = 4,
    parameter int AW           = 13,
    parameter int CHW          = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_take,
    input  pix_t           in_pix,
    input  lsh_ctrl_t      in_ctrl,
    input  logic [AW-1:0]  in_addr,
    input  logic [CHW-1:0] tap,
    input  pix_t           centre,
    input  pix_t           up,
    input  pix_t           right,
    output logic           two_wr_en,
    output logic [AW-1:0]  two_wr_addr,
    output pix_t           two_wr_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pix_t           m_sharpened_value,
    output logic           m_frame_end,
    output logic           m_run_last
);

    logic          s1_valid_reg;
    lsh_ctrl_t     s1_ctrl_reg;
    pix_t          s1_pix_reg;
    logic [AW-1:0] s1_addr_reg;

    logic s2_valid_reg;
    pix_t s2_value_reg;
    logic s2_two_reg;
    logic s2_fe_reg;
    logic s2_phase_reg;

    pix_t hist_reg [MAX_CHANNELS];

    logic               s2_last;
    logic               s2_free;
    logic               move;
    pix_t               left;
    logic [10:0]        five_c;
    logic [9:0]         neigh;
    logic signed [11:0] diff;
    pix_t               clamped;
    pix_t               value_next;

    assign s2_last = !s2_two_reg || s2_phase_reg;
    assign s2_free = !s2_valid_reg || (m_ready && s2_last);
    assign in_take = !s1_valid_reg || s2_free;
    assign move    = s1_valid_reg && s2_free;
    assign left    = hist_reg[tap];

    always_comb begin
        five_c = {1'b0, centre, 2'b00} + {3'b000, centre};
        neigh  = {2'b00, left} + {2'b00, right} + {2'b00, up} + {2'b00, s1_pix_reg};
        diff   = $signed({1'b0, five_c}) - $signed({2'b00, neigh});
        priority if (diff < 0) begin
            clamped = '0;
        end else if (diff > 12'sd255) begin
            clamped = '1;
        end else begin
            clamped = diff[7:0];
        end
        value_next = s1_ctrl_reg.border ? '0 : clamped;
    end

    assign two_wr_en   = move;
    assign two_wr_addr = s1_addr_reg;
    assign two_wr_data = centre;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_take) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            s1_ctrl_reg <= in_ctrl;
            s1_pix_reg  <= in_pix;
            s1_addr_reg <= in_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            hist_reg[0] <= centre;
            for (int i = 1; i < MAX_CHANNELS; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s2_phase_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= move && s1_ctrl_reg.emit;
            s2_phase_reg <= 1'b0;
        end else if (m_ready) begin
            s2_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_free) begin
            s2_value_reg <= value_next;
            s2_two_reg   <= s1_ctrl_reg.last_row;
            s2_fe_reg    <= s1_ctrl_reg.frame_end;
        end
    end

    assign m_valid           = s2_valid_reg;
    assign m_sharpened_value = s2_phase_reg ? '0 : s2_value_reg;
    assign m_frame_end       = s2_phase_reg && s2_fe_reg;
    assign m_run_last        = s2_last;

endmodule

// ----- sv/laplacian_sharpen_3x3.sv -----
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// Output path: the first result word of an input is registered in the read
// stage (s1), then the output register (s2); the second word of a pair follows
// in the cycle after the first is taken. Throughput: one input word per cycle
// while m_ready holds; last-row inputs give two words and wait on the output.
// Reset: synchronous, active low; clears positions, handshake state and
// registers to defaults. Line memories are not cleared.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3
    import lsh_pkg::*;
#(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pix_t                  s_pixel_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pix_t                  m_sharpened_value,
    output logic                  m_frame_end,
    output logic                  m_run_last
);

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int NW    = $clog2(MAX_CHANNELS + 1);
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [11:0]   width_reg;
    logic [15:0]   height_reg;
    logic [2:0]    chan_reg;
    logic [AW-1:0] col_reg;
    logic [15:0]   row_reg;

    logic [WW-1:0]  eff_w;
    logic [NW-1:0]  eff_ch;
    logic [15:0]    eff_h;
    logic [LW-1:0]  len;
    logic [LW-1:0]  col_ext;
    logic [CHW-1:0] tap;
    logic [AW-1:0]  addr_right;
    logic           cfg_hit;
    logic           in_acc;
    logic           col_wrap;
    logic           row_wrap;
    lsh_ctrl_t      ctrl;

    pix_t centre;
    pix_t up;
    pix_t right;
    logic          two_wr_en;
    logic [AW-1:0] two_wr_addr;
    pix_t          two_wr_data;

    always_comb begin
        priority if (width_reg < 12'd3) begin
            eff_w = WW'(3);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(width_reg);
        end
        priority if (chan_reg == 3'd0) begin
            eff_ch = NW'(1);
        end else if (int'(chan_reg) > MAX_CHANNELS) begin
            eff_ch = NW'(MAX_CHANNELS);
        end else begin
            eff_ch = NW'(chan_reg);
        end
        eff_h = (height_reg < 16'd3) ? 16'd3 : height_reg;
    end

    assign len        = LW'(eff_w) * LW'(eff_ch);
    assign col_ext    = LW'(col_reg);
    assign tap        = CHW'(eff_ch - NW'(1));
    assign addr_right = col_reg + AW'(eff_ch);
    assign col_wrap   = (col_ext == len - LW'(1));
    assign row_wrap   = (row_reg == eff_h - 16'd1);

    always_comb begin
        ctrl.emit      = (row_reg != 16'd0);
        ctrl.border    = (row_reg == 16'd1) || (col_ext < LW'(eff_ch)) ||
                         (col_ext >= len - LW'(eff_ch));
        ctrl.last_row  = row_wrap;
        ctrl.frame_end = col_wrap;
    end

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == CFG_IMAGE_WIDTH ||
                       cfg_index == CFG_IMAGE_HEIGHT || cfg_index == CFG_CHANNEL_COUNT);
    assign in_acc    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            chan_reg   <= CHANNELS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[11:0];
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                CFG_CHANNEL_COUNT: chan_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_hit) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_acc) begin
            if (col_wrap) begin
                col_reg <= '0;
                row_reg <= row_wrap ? 16'd0 : row_reg + 16'd1;
            end else begin
                col_reg <= col_reg + AW'(1);
            end
        end
    end

    lsh_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk          (aclk),
        .rd_en         (s_ready),
        .rd_addr       (col_reg),
        .rd_addr_right (addr_right),
        .one_wr_en     (in_acc),
        .one_wr_data   (s_pixel_value),
        .two_wr_en     (two_wr_en),
        .two_wr_addr   (two_wr_addr),
        .two_wr_data   (two_wr_data),
        .centre        (centre),
        .up            (up),
        .right         (right)
    );

    lsh_kernel #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW),
        .CHW          (CHW)
    ) u_kernel (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_valid),
        .in_take           (s_ready),
        .in_pix            (s_pixel_value),
        .in_ctrl           (ctrl),
        .in_addr           (col_reg),
        .tap               (tap),
        .centre            (centre),
        .up                (up),
        .right             (right),
        .two_wr_en         (two_wr_en),
        .two_wr_addr       (two_wr_addr),
        .two_wr_data       (two_wr_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sharpened_value (m_sharpened_value),
        .m_frame_end       (m_frame_end),
        .m_run_last        (m_run_last)
    );

endmodule

// ----- sv/lsh_checker.sv -----
// ----------------------------------------------------------------------------
// lsh_checker
// Port-level checks of the sharpening filter's output stream.
// ----------------------------------------------------------------------------
module lsh_checker
    import lsh_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input pix_t m_sharpened_value,
    input logic m_frame_end,
    input logic m_run_last
);

    // frame end only comes on the trailing border word of an input
    a_fe_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_last && m_sharpened_value == '0)
        else $error("frame_end on a non-final or nonzero word");

    // second word of a pair follows at once
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid && m_run_last)
        else $error("second word of a pair missing");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sharpened_value))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind laplacian_sharpen_3x3 lsh_checker u_lsh_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_sharpened_value (m_sharpened_value),
    .m_frame_end       (m_frame_end),
    .m_run_last        (m_run_last)
);
